### hw/rtl/sms_pkg.sv
package sms_pkg;

  localparam int MAX_TASKS = 64;
  localparam int TIME_BITS = 16;
  localparam int OUT_BITS  = 23;
  localparam int IDX_BITS  = $clog2(MAX_TASKS);
  localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);

  typedef logic [TIME_BITS-1:0] tval_t;
  typedef logic [OUT_BITS-1:0]  oval_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef struct packed {
    tval_t rel;
    tval_t proc;
    tval_t dlv;
  } task_t;

  localparam int TASK_BITS = $bits(task_t);

  // running result of one pass over the stored tasks
  typedef struct packed {
    logic  found;
    logic  pending;
    idx_t  idx;
    tval_t proc;
    tval_t dlv;
    tval_t earliest;
  } pick_t;

  function automatic oval_t sat_add(input oval_t a, input tval_t b);
    logic [OUT_BITS:0] sum;
    sum = {1'b0, a} + (OUT_BITS + 1)'(b);
    return sum[OUT_BITS] ? {OUT_BITS{1'b1}} : sum[OUT_BITS-1:0];
  endfunction

endpackage

### hw/rtl/schrage_makespan_scheduler.sv
// Single-machine Schrage scheduler. Tasks (release, processing, delivery)
// load at one per cycle into a 64 x 48 task RAM; a transfer with last_task
// set closes the set and starts scheduling, and in_ready stays low until
// the result is handed to the output register. Each scheduling step reads
// the n stored tasks through the RAM's single read port, one per cycle,
// then waits for the read latency, the end of the scan, the decision and
// the finish time; a step that finds no released task jumps idle to the
// next release time and scans again. The result
// carries Cmax and an overflow flag for tasks dropped beyond 64 stored; the
// next set may load while that result waits to be taken.
module schrage_makespan_scheduler (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sms_pkg::tval_t        release_time,
  input  sms_pkg::tval_t        processing_time,
  input  sms_pkg::tval_t        delivery_time,
  input  logic                  last_task,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sms_pkg::oval_t        makespan,
  output logic                  overflow
);

  import sms_pkg::*;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_FIN    = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]           state;
  cnt_t                 count;
  cnt_t                 left;
  cnt_t                 scan_cnt;
  logic [MAX_TASKS-1:0] done;
  oval_t                cur_time;
  oval_t                best;
  logic                 dropped;
  logic                 rd_vld;
  idx_t                 rd_idx;

  logic                 in_xfer;
  logic                 store;
  logic                 issue;
  logic                 start;
  task_t                wr_task;
  task_t                rd_task;
  logic [TASK_BITS-1:0] rd_word;
  pick_t                sel;
  oval_t                fin;

  assign in_ready = (state == ST_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign store    = in_xfer && (count < cnt_t'(MAX_TASKS));
  assign issue    = (state == ST_SCAN) && (scan_cnt < count);
  assign fin      = sat_add(cur_time, sel.dlv);

  assign wr_task.rel  = release_time;
  assign wr_task.proc = processing_time;
  assign wr_task.dlv  = delivery_time;
  assign rd_task      = task_t'(rd_word);

  assign start = (in_xfer && last_task) ||
                 (state == ST_DECIDE && !sel.found) ||
                 (state == ST_FIN && left != '0);

  sms_task_ram #(
    .DEPTH (MAX_TASKS),
    .WIDTH (TASK_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (count[IDX_BITS-1:0]),
    .wr_data (wr_task),
    .rd_addr (scan_cnt[IDX_BITS-1:0]),
    .rd_data (rd_word)
  );

  sms_select u_select (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .entry_valid (rd_vld),
    .entry_done  (done[rd_idx]),
    .entry_idx   (rd_idx),
    .entry       (rd_task),
    .now         (cur_time),
    .sel         (sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      left      <= '0;
      scan_cnt  <= '0;
      done      <= '0;
      cur_time  <= '0;
      best      <= '0;
      dropped   <= 1'b0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_vld <= issue;
      if (issue) begin
        rd_idx   <= scan_cnt[IDX_BITS-1:0];
        scan_cnt <= scan_cnt + cnt_t'(1);
      end
      if (start) begin
        scan_cnt <= '0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (store) begin
              count <= count + cnt_t'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last_task) begin
              left  <= store ? count + cnt_t'(1) : count;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!issue && !rd_vld) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (sel.found) begin
            done[sel.idx] <= 1'b1;
            left          <= left - cnt_t'(1);
            cur_time      <= sat_add(cur_time, sel.proc);
            state         <= ST_FIN;
          end else begin
            cur_time <= oval_t'(sel.earliest);
            state    <= ST_SCAN;
          end
        end
        ST_FIN: begin
          if (fin > best) begin
            best <= fin;
          end
          state <= (left == '0) ? ST_EMIT : ST_SCAN;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            makespan  <= best;
            overflow  <= dropped;
            count     <= '0;
            done      <= '0;
            cur_time  <= '0;
            best      <= '0;
            dropped   <= 1'b0;
            state     <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

### hw/rtl/sms_task_ram.sv
module sms_task_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/sms_select.sv
module sms_select (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           entry_valid,
  input  logic           entry_done,
  input  sms_pkg::idx_t  entry_idx,
  input  sms_pkg::task_t entry,
  input  sms_pkg::oval_t now,
  output sms_pkg::pick_t sel
);

  import sms_pkg::*;

  logic released;
  logic better;
  logic earlier;

  assign released = oval_t'(entry.rel) <= now;
  assign better   = !sel.found || (entry.dlv > sel.dlv);
  assign earlier  = !sel.pending || (entry.rel < sel.earliest);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      sel.found   <= 1'b0;
      sel.pending <= 1'b0;
    end else if (entry_valid && !entry_done) begin
      if (earlier) begin
        sel.earliest <= entry.rel;
        sel.pending  <= 1'b1;
      end
      // strict compare keeps the lowest index on equal delivery times
      if (released && better) begin
        sel.found <= 1'b1;
        sel.idx   <= entry_idx;
        sel.proc  <= entry.proc;
        sel.dlv   <= entry.dlv;
      end
    end
  end

endmodule

### hw/rtl/sms_checker.sv
module sms_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           last_task,
  input logic           out_valid,
  input logic           out_ready,
  input sms_pkg::oval_t makespan,
  input logic           overflow
);

  import sms_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(makespan) && $stable(overflow))
    else $error("result changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_task |=> !in_ready)
    else $error("input taken during scheduling");

  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_task |=> in_ready)
    else $error("load stalled mid set");

endmodule

bind schrage_makespan_scheduler sms_checker u_sms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last_task (last_task),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .makespan  (makespan),
  .overflow  (overflow)
);
